@@ src/sfprng_pkg.sv @@
// package for the small fast prng with range unit
// holds the state type, seeding constants and the one-round update function
// no dependencies
`default_nettype none

package sfprng_pkg;

   localparam int WORD_W        = 32;
   localparam int WARMUP_ROUNDS = 20;
   localparam int ROUND_CNT_W   = (WARMUP_ROUNDS > 0) ? $clog2(WARMUP_ROUNDS + 1) : 1;

   localparam logic [WORD_W-1:0] SEED_FIRST_WORD = 32'hf1ea5eed;
   localparam logic [WORD_W-1:0] SEED_RESET      = 32'd123;

   localparam int ROT_B = 27;
   localparam int ROT_C = 17;

   typedef struct packed {
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic [WORD_W-1:0] word_c;
      logic [WORD_W-1:0] word_d;
   } prng_state_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int k);
      return (v << k) | (v >> (WORD_W - k));
   endfunction

   function automatic prng_state_type seed_state(input logic [WORD_W-1:0] seed);
      prng_state_type s;
      s.word_a = SEED_FIRST_WORD;
      s.word_b = seed;
      s.word_c = seed;
      s.word_d = seed;
      return s;
   endfunction

   // one generator round; the draw is the new word_d
   function automatic prng_state_type advance(input prng_state_type s);
      logic [WORD_W-1:0] e;
      prng_state_type    n;
      e        = s.word_a - rotl(s.word_b, ROT_B);
      n.word_a = s.word_b ^ rotl(s.word_c, ROT_C);
      n.word_b = s.word_c + s.word_d;
      n.word_c = s.word_d + e;
      n.word_d = e + n.word_a;
      return n;
   endfunction

endpackage

`default_nettype wire

@@ src/small_fast_prng_with_range_unit.sv @@
// A 32-bit small fast pseudo-random generator with range scaling. Each request
// advances the generator once and returns either the raw draw or the draw scaled
// into 0 to range_size-1 (high half of draw times range_size; 0 if range_size is 0).
// One request is taken per cycle unless a stalled response holds the pipe; the state
// update sits between the request port and a draw register, the 32x32 multiply between
// that register and the response register. After reset and after every seed
// write the generator reseeds and runs WARMUP_ROUNDS (20) rounds, one per cycle,
// with req_ready low. Seed writes take effect at once and must only be made
// while no request is in flight.
// depends on sfprng_pkg
`default_nettype none

module small_fast_prng_with_range_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_range_size,
   input  wire logic        req_want_raw,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_draw
);

   sfprng_pkg::prng_state_type              state_ff, state_in, state_next;
   logic [sfprng_pkg::ROUND_CNT_W-1:0]      rounds_left_ff, rounds_left_in;
   logic                                    s1_valid_ff, s1_valid_in;
   logic [sfprng_pkg::WORD_W-1:0]           s1_value_ff, s1_value_in;
   logic [sfprng_pkg::WORD_W-1:0]           s1_range_ff, s1_range_in;
   logic                                    s1_raw_ff, s1_raw_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [sfprng_pkg::WORD_W-1:0]           rsp_draw_ff, rsp_draw_in;
   logic [2*sfprng_pkg::WORD_W-1:0]         product;
   logic                                    warming, out_free, s1_free, accept;

   assign warming   = (rounds_left_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_ready = !reset && !warming && s1_free;
   assign accept    = req_valid && req_ready;

   assign state_next = sfprng_pkg::advance(state_ff);
   assign product    = {{sfprng_pkg::WORD_W{1'b0}}, s1_value_ff} *
                       {{sfprng_pkg::WORD_W{1'b0}}, s1_range_ff};

   always_comb begin
      state_in       = state_ff;
      rounds_left_in = rounds_left_ff;
      if (csr_we) begin
         state_in       = sfprng_pkg::seed_state(csr_wdata);
         rounds_left_in = sfprng_pkg::ROUND_CNT_W'(sfprng_pkg::WARMUP_ROUNDS);
      end else if (warming) begin
         state_in       = state_next;
         rounds_left_in = rounds_left_ff - 1'b1;
      end else if (accept) begin
         state_in = state_next;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_value_in = s1_value_ff;
      s1_range_in = s1_range_ff;
      s1_raw_in   = s1_raw_ff;
      if (s1_free) begin
         s1_valid_in = accept;
      end
      if (accept) begin
         s1_value_in = state_next.word_d;
         s1_range_in = req_range_size;
         s1_raw_in   = req_want_raw;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_draw_in  = rsp_draw_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_draw_in  = s1_raw_ff ? s1_value_ff
                                  : product[2*sfprng_pkg::WORD_W-1:sfprng_pkg::WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sfprng_pkg::seed_state(sfprng_pkg::SEED_RESET);
         rounds_left_ff <= sfprng_pkg::ROUND_CNT_W'(sfprng_pkg::WARMUP_ROUNDS);
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rounds_left_ff <= rounds_left_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= s1_value_in;
      s1_range_ff <= s1_range_in;
      s1_raw_ff   <= s1_raw_in;
      rsp_draw_ff <= rsp_draw_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_draw  = rsp_draw_ff;

endmodule

`default_nettype wire

@@ src/sfprng_checker.sv @@
// port-level assertions for the small fast prng with range unit
// bound to small_fast_prng_with_range_unit; depends on sfprng_pkg
`default_nettype none

module sfprng_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        csr_we,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_draw
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_draw))
      else $error("response changed while stalled");

   // a seed write starts warm-up
   a_seed_warmup: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (sfprng_pkg::WARMUP_ROUNDS == 0) || !req_ready)
      else $error("request taken during warm-up");

   // reset empties the pipe and blocks requests
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && ((sfprng_pkg::WARMUP_ROUNDS == 0) || !req_ready))
      else $error("pipe not cleared by reset");

   // a fresh response comes from an accepted request, through the draw and response registers
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without request");

endmodule

bind small_fast_prng_with_range_unit sfprng_checker u_sfprng_checker (
   .clock     (clock),
   .reset     (reset),
   .csr_we    (csr_we),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_draw  (rsp_draw)
);

`default_nettype wire

@@ sim/tb_small_fast_prng_with_range_unit.sv @@
// self-checking testbench for small_fast_prng_with_range_unit: seeds, range scaling,
// raw draws, random traffic and back-pressure, checked against an in-bench generator model
// depends on sfprng_pkg and the unit under test
`timescale 1ns / 1ps

module tb_small_fast_prng_with_range_unit;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 11;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RANDOM_ITEMS     = 1100;
   localparam int RANDOM_PHASES    = 8;
   localparam int IDLE_PCT         = 38;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_we         = 1'b0;
   logic [31:0] csr_wdata      = '0;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [31:0] req_range_size = '0;
   logic        req_want_raw   = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_draw;

   small_fast_prng_with_range_unit uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_range_size (req_range_size),
      .req_want_raw   (req_want_raw),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_draw       (rsp_draw)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // generator model
   sfprng_pkg::prng_state_type gen_state;
   logic [31:0]                gen_seed;
   bit                         reseed_pending;

   logic [31:0] expected_draws[$];
   logic [31:0] oldest_draw;

   int error_count     = 0;
   int cycle_count     = 0;
   int requests_sent   = 0;
   int raw_requests    = 0;
   int zero_range_reqs = 0;
   int seed_writes     = 0;
   int draws_checked   = 0;
   int req_idle_pct    = IDLE_PCT;
   int rsp_idle_pct    = IDLE_PCT;
   bit long_hold_pending = 1'b0;

   function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned k);
      return (v << k) | (v >> (32 - k));
   endfunction

   function automatic void gen_round();
      logic [31:0] e;
      e = gen_state.word_a - rot_left(gen_state.word_b, 27);
      gen_state.word_a = gen_state.word_b ^ rot_left(gen_state.word_c, 17);
      gen_state.word_b = gen_state.word_c + gen_state.word_d;
      gen_state.word_c = gen_state.word_d + e;
      gen_state.word_d = e + gen_state.word_a;
   endfunction

   function automatic logic [31:0] predict_draw(input logic [31:0] range_size,
                                                input logic want_raw);
      logic [63:0] product;
      if (reseed_pending) begin
         gen_state.word_a = sfprng_pkg::SEED_FIRST_WORD;
         gen_state.word_b = gen_seed;
         gen_state.word_c = gen_seed;
         gen_state.word_d = gen_seed;
         for (int i = 0; i < sfprng_pkg::WARMUP_ROUNDS; i++) begin
            gen_round();
         end
         reseed_pending = 1'b0;
      end
      gen_round();
      product = {32'd0, gen_state.word_d} * {32'd0, range_size};
      return want_raw ? gen_state.word_d : product[63:32];
   endfunction

   function automatic logic [31:0] random_range_size();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return $urandom_range(16, 1);
         2: return 32'hffffffff - $urandom_range(15);
         3: return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_draws.size() == 0) begin
            report_mismatch($sformatf("draw %h with no request outstanding", rsp_draw));
         end else begin
            oldest_draw = expected_draws.pop_front();
            if (rsp_draw !== oldest_draw) begin
               report_mismatch($sformatf("draw got %h, expected %h", rsp_draw, oldest_draw));
            end
            draws_checked++;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_small_fast_prng_with_range_unit: FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] range_size, input logic want_raw);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_range_size <= range_size;
      req_want_raw   <= want_raw;
      do @(posedge clock); while (!req_ready);
      expected_draws.push_back(predict_draw(range_size, want_raw));
      requests_sent++;
      if (want_raw) raw_requests++;
      else if (range_size == 0) zero_range_reqs++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we   <= 1'b0;
      gen_seed       = value;
      reseed_pending = 1'b1;
      seed_writes++;
   endtask

   task automatic test_reset_seed();
      repeat (3) send_request($urandom, 1'b1);
   endtask

   task automatic test_range_extremes();
      send_request(32'd0, 1'b0);
      send_request(32'd1, 1'b0);
      send_request(32'hffffffff, 1'b0);
      send_request(32'h80000000, 1'b0);
      send_request(32'hffffffff, 1'b1);
      send_request(32'd0, 1'b1);
   endtask

   task automatic test_seed_writes();
      write_seed(32'd0);
      send_request(32'hffffffff, 1'b0);
      send_request(32'd0, 1'b1);
      write_seed(32'hffffffff);
      send_request(32'h0000ffff, 1'b0);
      send_request(32'd0, 1'b1);
      // two writes in a row: only the last seed counts
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= 32'h13579bdf;
      @(posedge clock);
      csr_wdata <= 32'h2468ace0;
      @(posedge clock);
      csr_we <= 1'b0;
      gen_seed       = 32'h2468ace0;
      reseed_pending = 1'b1;
      seed_writes += 2;
      send_request(32'd1000, 1'b0);
      send_request(32'd0, 1'b1);
      write_seed(sfprng_pkg::SEED_RESET);
      send_request(32'd7, 1'b0);
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_seed($urandom);
         // one phase runs with no idling on either side
         req_idle_pct = (p == 3) ? 0 : IDLE_PCT;
         rsp_idle_pct = (p == 3) ? 0 : IDLE_PCT;
         for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
            send_request(random_range_size(), $urandom_range(1));
         end
      end
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   task automatic test_backpressure();
      req_idle_pct      = 0;
      long_hold_pending = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_request(random_range_size(), $urandom_range(1));
      end
      req_idle_pct = IDLE_PCT;
   endtask

   initial begin
      gen_seed       = sfprng_pkg::SEED_RESET;
      reseed_pending = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_seed();
      test_range_extremes();
      test_seed_writes();
      test_random_traffic();
      test_backpressure();

      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_draws.size() != 0) begin
         report_mismatch($sformatf("%0d draws never returned", expected_draws.size()));
      end

      $display("covered %0d requests (%0d raw, %0d zero range) over %0d seed writes",
               requests_sent, raw_requests, zero_range_reqs, seed_writes);
      $display("%0d draws checked, including a long receiver hold-off", draws_checked);
      if (error_count == 0) begin
         $display("tb_small_fast_prng_with_range_unit: PASS");
      end else begin
         $display("tb_small_fast_prng_with_range_unit: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/sfprng_pkg.sv
src/small_fast_prng_with_range_unit.sv
src/sfprng_checker.sv
sim/tb_small_fast_prng_with_range_unit.sv
